// ===== design/bpq_pkg.sv =====
// Shared types and constants for the bounding-volume point query block.
// Used by the channel interfaces and by bvh_point_leaf_query; depends on nothing.
package bpq_pkg;

   localparam int NODE_COUNT_DEF   = 1024;
   localparam int QUEUE_DEPTH_DEF  = 32;
   localparam int MAX_SECTIONS_DEF = 8;
   localparam int POS_SCALE_DEF    = 256;

   localparam int COORD_W   = 16;
   localparam int POINT_W   = 32;
   localparam int LINK_W    = 32;
   localparam int SECTION_W = 31;
   localparam int ADDR_W    = 10;
   localparam int ORD_W     = 4;
   localparam int LEAF_BIT  = 31;

   // Quotient bits retired by the divider in one cycle.
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = POINT_W / DIV_BITS;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic [ADDR_W-1:0]          node_addr;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_min_z;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
      logic signed [COORD_W-1:0]  box_max_z;
      logic [LINK_W-1:0]          link_word;
      logic signed [POINT_W-1:0]  point_x;
      logic signed [POINT_W-1:0]  point_y;
      logic signed [POINT_W-1:0]  point_z;
   } bpq_req_word_type;

   typedef struct packed {
      logic [SECTION_W-1:0] section_index;
      logic                 found;
      logic [ORD_W-1:0]     ordinal;
      logic                 last;
   } bpq_rsp_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
      logic [LINK_W-1:0]         link;
   } bpq_node_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV,
      ST_VISIT,
      ST_TEST,
      ST_EMIT_RD,
      ST_EMIT
   } bpq_state_type;

endpackage

// ===== design/bpq_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on bpq_pkg for the payload structs.
interface bpq_req_if;
   import bpq_pkg::*;
   logic             valid;
   logic             ready;
   bpq_req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bpq_rsp_if;
   import bpq_pkg::*;
   logic             valid;
   logic             ready;
   bpq_rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/bvh_point_leaf_query.sv =====
// Channel     | Dir | Word                    | Accepted when
// req_chan    | in  | node write or point     | req_chan.valid && req_chan.ready
// rsp_chan    | out | section, found, ord     | rsp_chan.valid && rsp_chan.ready
//
// A query scales the point through the shared restoring divider, then visits nodes (node
// memory read, then box test), then emits each result word (section store read, then
// offer). Reset is synchronous and clears the sequencer and queue pointers; the node memory
// holds whatever was written. The request side is not ready until the last response word
// of a query has been taken; a stalled response simply holds its word.
module bvh_point_leaf_query #(
   parameter int NODE_COUNT   = bpq_pkg::NODE_COUNT_DEF,
   parameter int QUEUE_DEPTH  = bpq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_SECTIONS = bpq_pkg::MAX_SECTIONS_DEF,
   parameter int POS_SCALE    = bpq_pkg::POS_SCALE_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpq_req_if.sink   req_chan,
   bpq_rsp_if.source rsp_chan
);
   import bpq_pkg::*;

   localparam int AW          = $clog2(NODE_COUNT);
   localparam int QW          = $clog2(QUEUE_DEPTH);
   localparam int SW          = $clog2(MAX_SECTIONS + 1);
   localparam int SIW         = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int VISIT_LIMIT = 4 * NODE_COUNT + 64;
   localparam int VW          = $clog2(VISIT_LIMIT + 1);
   localparam int RW          = $clog2(POS_SCALE) + 2;
   localparam int CW          = $clog2(DIV_STEPS);

   localparam logic [LINK_W-1:0] NODE_LIM  = LINK_W'(NODE_COUNT);
   localparam logic [RW-1:0]     SCALE_R   = RW'(POS_SCALE);
   localparam logic [VW-1:0]     VISIT_MAX = VW'(VISIT_LIMIT);
   localparam logic [SW-1:0]     SECT_MAX  = SW'(MAX_SECTIONS);
   localparam logic [QW-1:0]     Q_LAST    = QW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0]     STEP_LAST = CW'(DIV_STEPS - 1);

   // Storage
   bpq_node_type              node_mem [NODE_COUNT];
   bpq_node_type              node_rd_ff;
   logic [SECTION_W-1:0]      sect_mem [MAX_SECTIONS];
   logic [SECTION_W-1:0]      sect_rd_ff;
   logic [LINK_W-1:0]         queue_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    qvalid_ff;

   // Sequencer and datapath registers
   bpq_state_type             state_ff, state_in;
   logic [POINT_W-1:0]        pt_ff [3];
   logic signed [COORD_W-1:0] pos_ff [3];
   logic [1:0]                coord_ff, coord_in;
   logic [POINT_W-1:0]        num_ff, num_in;
   logic [RW-1:0]             rem_ff, rem_in;
   logic [CW-1:0]             step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic [QW-1:0]             head_ff, head_in;
   logic [QW-1:0]             tail_ff, tail_in;
   logic [SW-1:0]             found_ff, found_in;
   logic [VW-1:0]             visits_ff, visits_in;
   logic                      idx_ok_ff, idx_ok_in;
   logic [SIW-1:0]            emit_ff, emit_in;

   // Control strobes into the clocked stores
   logic                      node_we, sect_we, queue_we, queue_clr, pt_we, pos_we;
   logic [AW-1:0]             node_waddr, node_raddr;
   logic [QW-1:0]             tail_p1, tail_p2, head_p1;
   logic [LINK_W-1:0]         head_entry;
   logic [POINT_W-1:0]        div_num_nx, div_mag;
   logic [RW-1:0]             div_rem_nx;
   logic [COORD_W-1:0]        quo_lo;
   logic                      hit, walk_on, last_word;
   bpq_rsp_word_type          rsp_word;
   bpq_req_word_type          rq;

   assign rq = req_chan.payload;

   // One restoring divide step per quotient bit; the quotient shifts into num.
   always_comb begin
      logic [RW-1:0]      r;
      logic [POINT_W-1:0] n;
      r = rem_ff;
      n = num_ff;
      for (int b = 0; b < DIV_BITS; b++) begin
         r = {r[RW-2:0], n[POINT_W-1]};
         n = {n[POINT_W-2:0], 1'b0};
         if (r >= SCALE_R) begin
            r    = r - SCALE_R;
            n[0] = 1'b1;
         end
      end
      div_rem_nx = r;
      div_num_nx = n;
   end

   assign div_mag    = pt_ff[coord_ff][POINT_W-1] ? (~pt_ff[coord_ff] + 1'b1) : pt_ff[coord_ff];
   assign quo_lo     = neg_ff ? (~div_num_nx[COORD_W-1:0] + 1'b1) : div_num_nx[COORD_W-1:0];

   assign tail_p1    = (tail_ff == Q_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_p2    = (tail_p1 == Q_LAST) ? '0 : tail_p1 + 1'b1;
   assign head_p1    = (head_ff == Q_LAST) ? '0 : head_ff + 1'b1;
   assign head_entry = qvalid_ff[head_ff] ? queue_ff[head_ff] : '0;

   assign walk_on    = (head_ff != tail_ff) && (found_ff < SECT_MAX) && (visits_ff < VISIT_MAX);

   assign hit = (pos_ff[0] >= node_rd_ff.min_x) && (pos_ff[0] <= node_rd_ff.max_x) &&
                (pos_ff[1] >= node_rd_ff.min_y) && (pos_ff[1] <= node_rd_ff.max_y) &&
                (pos_ff[2] >= node_rd_ff.min_z) && (pos_ff[2] <= node_rd_ff.max_z);

   assign last_word  = (found_ff == '0) || ({{(SW > SIW ? SW - SIW : 0){1'b0}}, emit_ff}
                       == SW'(found_ff - 1'b1));

   assign node_waddr = AW'(rq.node_addr);
   assign node_raddr = AW'(head_entry);

   always_comb begin
      rsp_word               = '0;
      rsp_word.last          = last_word;
      if (found_ff != '0) begin
         rsp_word.found         = 1'b1;
         rsp_word.section_index = sect_rd_ff;
         rsp_word.ordinal       = ORD_W'(emit_ff) + ORD_W'(1);
      end
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = (state_ff == ST_EMIT);
   assign rsp_chan.payload = rsp_word;

   always_comb begin
      state_in  = state_ff;
      coord_in  = coord_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      found_in  = found_ff;
      visits_in = visits_ff;
      idx_ok_in = idx_ok_ff;
      emit_in   = emit_ff;
      node_we   = 1'b0;
      sect_we   = 1'b0;
      queue_we  = 1'b0;
      queue_clr = 1'b0;
      pt_we     = 1'b0;
      pos_we    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (rq.req_type == REQ_QUERY) begin
                  pt_we     = 1'b1;
                  queue_clr = 1'b1;
                  coord_in  = '0;
                  head_in   = '0;
                  tail_in   = QW'(1);
                  found_in  = '0;
                  visits_in = '0;
                  state_in  = ST_DIV_LOAD;
               end else begin
                  node_we = ({{(LINK_W - ADDR_W){1'b0}}, rq.node_addr} < NODE_LIM);
               end
            end
         end
         ST_DIV_LOAD: begin
            num_in   = div_mag;
            rem_in   = '0;
            step_in  = '0;
            // The negated point is negative exactly when the point is positive.
            neg_in   = !pt_ff[coord_ff][POINT_W-1] && (pt_ff[coord_ff] != '0);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            num_in  = div_num_nx;
            rem_in  = div_rem_nx;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               pos_we = 1'b1;
               if (coord_ff == 2'd2) begin
                  state_in = ST_VISIT;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = ST_DIV_LOAD;
               end
            end
         end
         ST_VISIT: begin
            if (walk_on) begin
               idx_ok_in = (head_entry < NODE_LIM);
               visits_in = visits_ff + 1'b1;
               state_in  = ST_TEST;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_TEST: begin
            if (idx_ok_ff && hit) begin
               if (node_rd_ff.link[LEAF_BIT]) begin
                  sect_we  = 1'b1;
                  found_in = found_ff + 1'b1;
               end else begin
                  queue_we = 1'b1;
                  tail_in  = tail_p2;
               end
            end
            head_in  = head_p1;
            state_in = ST_VISIT;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               if (last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= QW'(1);
         found_ff  <= '0;
         visits_ff <= '0;
         qvalid_ff <= '0;
         emit_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         found_ff  <= found_in;
         visits_ff <= visits_in;
         emit_ff   <= emit_in;
         if (queue_clr) begin
            qvalid_ff <= '0;
         end else if (queue_we) begin
            qvalid_ff[tail_ff] <= 1'b1;
            qvalid_ff[tail_p1] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      coord_ff  <= coord_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      idx_ok_ff <= idx_ok_in;
      if (pt_we) begin
         pt_ff[0] <= rq.point_x;
         pt_ff[1] <= rq.point_y;
         pt_ff[2] <= rq.point_z;
      end
      if (pos_we) begin
         pos_ff[coord_ff] <= quo_lo;
      end
      // Children sit at link and link + 1; a wrapped tail may overwrite live entries.
      if (queue_we) begin
         queue_ff[tail_ff] <= node_rd_ff.link;
         queue_ff[tail_p1] <= node_rd_ff.link + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= '{min_x: rq.box_min_x, min_y: rq.box_min_y,
                                   min_z: rq.box_min_z, max_x: rq.box_max_x,
                                   max_y: rq.box_max_y, max_z: rq.box_max_z,
                                   link: rq.link_word};
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (sect_we) begin
         sect_mem[found_ff[SIW-1:0]] <= node_rd_ff.link[SECTION_W-1:0];
      end
      sect_rd_ff <= sect_mem[emit_ff];
   end

endmodule

// ===== dv/bvh_point_leaf_query_tb.sv =====
// Self-checking testbench for bvh_point_leaf_query: loads node tables, sends point
// queries and checks every section word against its own tree walk.
// Depends on bpq_pkg, the bpq_req_if/bpq_rsp_if interfaces and the block itself.
module bvh_point_leaf_query_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpq_pkg::*;

   localparam int VISIT_LIMIT = 4 * NODE_COUNT_DEF + 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_AFTER  = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int WORD_TARGET = 184;

   logic clock;
   logic reset;

   bpq_req_if req_chan ();
   bpq_rsp_if rsp_chan ();

   bvh_point_leaf_query u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bpq_node_type     node_table [NODE_COUNT_DEF];
   bpq_req_word_type pending_words [$];
   bpq_rsp_word_type expected_sections [$];

   int word_total    = 0;
   int words_sent    = 0;
   int results_taken = 0;
   int send_gap      = 0;
   int take_gap      = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int fail_count    = 0;
   int cycle_count   = 0;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input bpq_rsp_word_type got,
                                  input bpq_rsp_word_type want);
      if (fail_count < 200) begin
         $display({"%0t ns mismatch:%s got sect=%0h found=%0b ord=%0d last=%0b,",
                   " want sect=%0h found=%0b ord=%0d last=%0b"},
                  $time, what, got.section_index, got.found, got.ordinal, got.last,
                  want.section_index, want.found, want.ordinal, want.last);
      end
      fail_count++;
   endtask

   // Idle cycles before the next word; every third stretch of 32 words runs back to back.
   function automatic int idle_draw(int seq);
      return ((seq / 32) % 3 == 1) ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic signed [COORD_W-1:0] scaled_coord(logic signed [POINT_W-1:0] p);
      longint q;
      q = -longint'(p) / POS_SCALE_DEF;
      return q[COORD_W-1:0];
   endfunction

   function automatic void store_node(bpq_req_word_type w);
      bpq_node_type nd;
      nd.min_x = w.box_min_x;
      nd.min_y = w.box_min_y;
      nd.min_z = w.box_min_z;
      nd.max_x = w.box_max_x;
      nd.max_y = w.box_max_y;
      nd.max_z = w.box_max_z;
      nd.link  = w.link_word;
      node_table[w.node_addr] = nd;
   endfunction

   // Breadth-first walk from the root through a small circular queue that may lap itself.
   function automatic void walk_tree(bpq_req_word_type w);
      logic signed [COORD_W-1:0] pos [3];
      logic [LINK_W-1:0]         walk_q [QUEUE_DEPTH_DEF];
      logic [SECTION_W-1:0]      sect [MAX_SECTIONS_DEF];
      logic [LINK_W-1:0]         idx;
      bpq_node_type              nd;
      bpq_rsp_word_type          r;
      int                        head;
      int                        tail;
      int                        hits;
      int                        visits;
      bit                        contains;
      pos[0] = scaled_coord(w.point_x);
      pos[1] = scaled_coord(w.point_y);
      pos[2] = scaled_coord(w.point_z);
      foreach (walk_q[i]) walk_q[i] = '0;
      head   = 0;
      tail   = 1 % QUEUE_DEPTH_DEF;
      hits   = 0;
      visits = 0;
      while (head != tail && hits < MAX_SECTIONS_DEF && visits < VISIT_LIMIT) begin
         idx = walk_q[head];
         visits++;
         if (idx < NODE_COUNT_DEF) begin
            nd = node_table[idx];
            contains = pos[0] >= nd.min_x && pos[0] <= nd.max_x &&
                       pos[1] >= nd.min_y && pos[1] <= nd.max_y &&
                       pos[2] >= nd.min_z && pos[2] <= nd.max_z;
            if (contains) begin
               if (!nd.link[LEAF_BIT]) begin
                  walk_q[tail] = nd.link;
                  tail = (tail + 1) % QUEUE_DEPTH_DEF;
                  walk_q[tail] = nd.link + 1;
                  tail = (tail + 1) % QUEUE_DEPTH_DEF;
               end else begin
                  sect[hits] = nd.link[SECTION_W-1:0];
                  hits++;
               end
            end
         end
         head = (head + 1) % QUEUE_DEPTH_DEF;
      end
      if (hits == 0) begin
         r = '0;
         r.last = 1'b1;
         expected_sections.push_back(r);
      end else begin
         for (int k = 0; k < hits; k++) begin
            r.section_index = sect[k];
            r.found         = 1'b1;
            r.ordinal       = ORD_W'(k + 1);
            r.last          = (k == hits - 1);
            expected_sections.push_back(r);
         end
      end
   endfunction

   function automatic bpq_req_word_type random_word();
      logic [255:0] raw;
      for (int i = 0; i < 8; i++) raw[i*32 +: 32] = $urandom;
      return raw[$bits(bpq_req_word_type)-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp16(int v);
      if (v < -32768) return -16'sd32768;
      if (v > 32767) return 16'sd32767;
      return v[COORD_W-1:0];
   endfunction

   function automatic bpq_node_type make_node(int lo, int hi, logic [LINK_W-1:0] link);
      bpq_node_type nd;
      nd.min_x = clamp16(lo);
      nd.min_y = clamp16(lo);
      nd.min_z = clamp16(lo);
      nd.max_x = clamp16(hi);
      nd.max_y = clamp16(hi);
      nd.max_z = clamp16(hi);
      nd.link  = link;
      return nd;
   endfunction

   function automatic void push_node(int addr, bpq_node_type nd);
      bpq_req_word_type w;
      w = random_word();
      w.req_type  = REQ_WRITE;
      w.node_addr = ADDR_W'(addr);
      w.box_min_x = nd.min_x;
      w.box_min_y = nd.min_y;
      w.box_min_z = nd.min_z;
      w.box_max_x = nd.max_x;
      w.box_max_y = nd.max_y;
      w.box_max_z = nd.max_z;
      w.link_word = nd.link;
      pending_words.push_back(w);
   endfunction

   function automatic void push_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      bpq_req_word_type w;
      w = random_word();
      w.req_type = REQ_QUERY;
      w.point_x  = px;
      w.point_y  = py;
      w.point_z  = pz;
      pending_words.push_back(w);
   endfunction

   // World coordinate that scales to p, with a random remainder and random upper bits
   // that the 16-bit wrap removes.
   function automatic logic [31:0] world_point(int p);
      int r;
      int m;
      r = $urandom_range(0, 255);
      m = $urandom_range(0, 120);
      if (p >= 0) return -(p * 256 + r + (m << 24));
      return -(p * 256 - r - (m << 24));
   endfunction

   function automatic void pick_span(int t, bit hit, output logic signed [COORD_W-1:0] lo,
                                     output logic signed [COORD_W-1:0] hi);
      if ($urandom_range(0, 9) == 0) begin
         lo = -16'sd32768;
         hi = 16'sd32767;
      end else if (hit) begin
         lo = clamp16(t - int'($urandom_range(0, 3000)));
         hi = clamp16(t + int'($urandom_range(0, 3000)));
      end else begin
         lo = COORD_W'($urandom);
         hi = COORD_W'($urandom);
      end
   endfunction

   task automatic build_directed();
      // Two levels of shared children reach the two leaves eight times over.
      push_node(0, make_node(-32768, 32767, 32'd1));
      push_node(1, make_node(-32768, 32767, 32'd3));
      push_node(2, make_node(-32768, 32767, 32'd3));
      push_node(3, make_node(-32768, 32767, 32'd5));
      push_node(4, make_node(-32768, 32767, 32'd5));
      push_node(5, make_node(-32768, 32767, 32'hffff_ffff));
      push_node(6, make_node(-32768, 32767, 32'h8000_0000));
      push_query(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      push_query(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      push_query(32'h0000_0000, 32'h0000_00ff, 32'hffff_ff01);
      // Root box misses the point.
      push_node(0, make_node(100, 100, 32'd1));
      push_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      // Second child falls just past the end of the table.
      push_node(0, make_node(-32768, 32767, 32'd1023));
      push_node(1023, make_node(-32768, 32767, 32'haaaa_aaaa));
      push_query(32'h1234_5678, 32'hedcb_a987, 32'h0000_0100);
      // Self-referencing interior nodes grow the queue until the tail laps the head.
      push_node(0, make_node(-32768, 32767, 32'd0));
      push_node(1, make_node(-32768, 32767, 32'd0));
      push_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      // A cycle that keeps the queue level runs until the visit cap stops it.
      push_node(0, make_node(-32768, 32767, 32'd5));
      push_node(5, make_node(-32768, 32767, 32'd0));
      push_node(6, make_node(1, 0, 32'h8000_0001));
      push_node(1, make_node(1, 0, 32'd3));
      push_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
   endtask

   // A fresh tree under node 0 whose boxes mostly surround one target point, then queries.
   task automatic build_scene();
      int               target [3];
      int               open_nodes [$];
      int               next_free;
      int               budget;
      int               addr;
      bit               hit;
      bpq_node_type     nd;
      bpq_req_word_type w;
      for (int a = 0; a < 3; a++) target[a] = int'($urandom_range(0, 65535)) - 32768;
      open_nodes.push_back(0);
      next_free = $urandom_range(1, 960);
      budget    = $urandom_range(0, 6);
      while (open_nodes.size() > 0) begin
         addr = open_nodes.pop_front();
         hit  = ($urandom_range(0, 4) != 0);
         pick_span(target[0], hit, nd.min_x, nd.max_x);
         pick_span(target[1], hit, nd.min_y, nd.max_y);
         pick_span(target[2], hit, nd.min_z, nd.max_z);
         if (budget > 0 && $urandom_range(0, 3) != 0) begin
            budget--;
            if ($urandom_range(0, 9) == 0) begin
               nd.link = $urandom_range(32'h7fff_ffff, NODE_COUNT_DEF);
            end else begin
               nd.link = next_free;
               open_nodes.push_back(next_free);
               open_nodes.push_back(next_free + 1);
               next_free += 2;
            end
         end else begin
            nd.link = {1'b1, 31'($urandom)};
         end
         push_node(addr, nd);
      end
      repeat ($urandom_range(2, 5)) begin
         if ($urandom_range(0, 3) != 0) begin
            push_query(world_point(target[0]), world_point(target[1]), world_point(target[2]));
         end else begin
            push_query($urandom, $urandom, $urandom);
         end
      end
      // Stray words: writes only to leaves or out-of-table children, and random points.
      repeat ($urandom_range(0, 2)) begin
         w = random_word();
         if (w.req_type == REQ_WRITE) begin
            w.link_word = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} :
                          $urandom_range(32'h7fff_ffff, NODE_COUNT_DEF);
         end
         pending_words.push_back(w);
      end
   endtask

   // Sender: holds a word until taken, then idles for its drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            if (req_chan.payload.req_type == REQ_WRITE) store_node(req_chan.payload);
            else walk_tree(req_chan.payload);
            words_sent <= words_sent + 1;
         end
         if (send_gap > 0 || pending_words.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_chan.payload <= pending_words.pop_front();
            req_chan.valid   <= 1'b1;
            send_gap         <= idle_draw(words_sent);
         end
      end
   end

   // Receiver: checks each section word against the oldest expectation.
   always @(posedge clock) begin : rsp_side
      int               next_gap;
      string            bad;
      bpq_rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap       <= 0;
      end else begin
         next_gap = (take_gap > 0) ? take_gap - 1 : 0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_sections.size() == 0) begin
               report_mismatch(" word with nothing expected", rsp_chan.payload, '0);
            end else begin
               want = expected_sections.pop_front();
               bad  = "";
               if (rsp_chan.payload.section_index !== want.section_index)
                  bad = {bad, " section_index"};
               if (rsp_chan.payload.found !== want.found) bad = {bad, " found"};
               if (rsp_chan.payload.ordinal !== want.ordinal) bad = {bad, " ordinal"};
               if (rsp_chan.payload.last !== want.last) bad = {bad, " last"};
               if (bad != "") report_mismatch(bad, rsp_chan.payload, want);
            end
            results_taken <= results_taken + 1;
            next_gap = idle_draw(results_taken);
         end
         take_gap       <= next_gap;
         rsp_chan.ready <= (next_gap == 0) && (hold_left == 0);
      end
   end

   // One long hold on the response side so the block backs up into its request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int drain;
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      build_directed();
      while (pending_words.size() < WORD_TARGET) build_scene();
      word_total = pending_words.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (words_sent != word_total) @(posedge clock);
      drain = 0;
      while (expected_sections.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (expected_sections.size() != 0) begin
         report_mismatch(" expected word never arrived", '0, expected_sections[0]);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bpq_pkg.sv
design/bpq_if.sv
design/bvh_point_leaf_query.sv
dv/bvh_point_leaf_query_tb.sv
